### src/tccw_pkg.sv
// ============================================================================
// Text console cell writer package
// Shared types, constants and default dimensions for the cell writer.
// ============================================================================
`default_nettype none

package tccw_pkg;

    // Default screen geometry.
    localparam int DEFAULT_COLUMNS = 80;
    localparam int DEFAULT_ROWS    = 24;

    // Width of a reported cell index.
    localparam int ADDR_W = 11;

    // Width used to form row * columns + column before the 11-bit mask.
    localparam int CALC_W = 12;

    // Input kinds carried in tuser.
    localparam logic CMD_CHAR    = 1'b0;
    localparam logic CMD_CONTROL = 1'b1;

    // Byte codes.
    localparam logic [7:0] ESCAPE_BYTE  = 8'h01;
    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [7:0] FG_MAX       = 8'h0F;
    localparam logic [7:0] COLOR_RESET  = 8'h07;

    typedef struct packed {
        logic       cmd;
        logic [7:0] char_code;
    } in_item_t;

    typedef struct packed {
        logic              cell_write;
        logic [ADDR_W-1:0] cell_address;
        logic [15:0]       cell_word;
        logic              cursor_moved;
        logic [ADDR_W-1:0] cursor_position;
    } result_t;

endpackage

`default_nettype wire

### src/tccw_in_reg.sv
// ============================================================================
// Cell writer input register
// Holds one accepted item until the engine consumes it.
// ============================================================================
`default_nettype none

module tccw_in_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire tccw_pkg::in_item_t in_item,
    input  wire logic              consume,
    output logic                   item_valid,
    output tccw_pkg::in_item_t     item
);

    logic               valid_reg;
    logic               valid_next;
    tccw_pkg::in_item_t item_reg;
    logic               load;

    // The slot is free when empty or when its item leaves this cycle.
    assign in_ready = !valid_reg || consume;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (consume)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

### src/tccw_engine.sv
// ============================================================================
// Cell writer engine
// Cursor, color and escape state with the per-item update and result logic.
// ============================================================================
`default_nettype none

module tccw_engine #(
    parameter int SCREEN_COLUMNS = tccw_pkg::DEFAULT_COLUMNS,
    parameter int SCREEN_ROWS    = tccw_pkg::DEFAULT_ROWS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               take,
    input  wire tccw_pkg::in_item_t item,
    output tccw_pkg::result_t       result
);

    localparam int COL_W = (SCREEN_COLUMNS > 1) ? $clog2(SCREEN_COLUMNS) : 1;
    localparam int ROW_W = (SCREEN_ROWS > 1) ? $clog2(SCREEN_ROWS) : 1;
    localparam int CW    = tccw_pkg::CALC_W;

    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [7:0]       color_reg;
    logic [7:0]       color_next;
    logic             esc_reg;
    logic             esc_next;

    logic [ROW_W-1:0] row_inc;
    logic             col_last;
    logic             wr;
    logic             moved;

    function automatic logic [tccw_pkg::ADDR_W-1:0] cell_index(
        input logic [ROW_W-1:0] r,
        input logic [COL_W-1:0] c
    );
        logic [CW-1:0] full;
        begin
            full = CW'(r) * CW'(SCREEN_COLUMNS) + CW'(c);
            cell_index = full[tccw_pkg::ADDR_W-1:0];
        end
    endfunction

    assign row_inc  = (row_reg == ROW_W'(SCREEN_ROWS - 1)) ? '0 : row_reg + 1'b1;
    assign col_last = (col_reg == COL_W'(SCREEN_COLUMNS - 1));

    always_comb
    begin
        row_next   = row_reg;
        col_next   = col_reg;
        color_next = color_reg;
        esc_next   = esc_reg;
        wr         = 1'b0;
        moved      = 1'b0;
        if (take)
        begin
            if (item.cmd == tccw_pkg::CMD_CHAR)
            begin
                if (item.char_code == tccw_pkg::ESCAPE_BYTE)
                begin
                    esc_next = 1'b1;
                end
                else if (esc_reg)
                begin
                    // The byte after an escape is swallowed; low codes set the foreground.
                    if (item.char_code <= tccw_pkg::FG_MAX)
                    begin
                        color_next = {color_reg[7:4], item.char_code[3:0]};
                    end
                    esc_next = 1'b0;
                end
                else
                begin
                    wr    = 1'b1;
                    moved = 1'b1;
                    if (col_last)
                    begin
                        col_next = '0;
                        row_next = row_inc;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
            end
            else if (item.char_code == tccw_pkg::NEWLINE_BYTE)
            begin
                col_next = '0;
                row_next = row_inc;
                moved    = 1'b1;
            end
        end
    end

    always_comb
    begin
        result.cell_write      = wr;
        result.cell_address    = wr ? cell_index(row_reg, col_reg) : '0;
        result.cell_word       = wr ? {color_reg, item.char_code} : '0;
        result.cursor_moved    = moved;
        result.cursor_position = cell_index(row_next, col_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= '0;
            col_reg   <= '0;
            color_reg <= tccw_pkg::COLOR_RESET;
            esc_reg   <= 1'b0;
        end
        else
        begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            color_reg <= color_next;
            esc_reg   <= esc_next;
        end
    end

endmodule

`default_nettype wire

### src/tccw_out_reg.sv
// ============================================================================
// Cell writer result register
// Holds one result item until the downstream side takes it.
// ============================================================================
`default_nettype none

module tccw_out_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire tccw_pkg::result_t result_in,
    output logic                   room,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output tccw_pkg::result_t      result_out
);

    logic              valid_reg;
    logic              valid_next;
    tccw_pkg::result_t result_reg;

    // A new result may enter when the register is empty or is drained this cycle.
    assign room = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

endmodule

`default_nettype wire

### src/text_console_cell_writer_unit.sv
// ============================================================================
// Text console cell writer
// Turns a byte stream into screen cell writes and cursor position updates.
// ============================================================================
// Each accepted item is held in the input register, then its result in the result register.
// Throughput: one item per clock while m_tready keeps the result register drained.
// Every item yields exactly one result item.
// Reset clears the cursor to cell 0, the escape flag, both stream registers,
// and sets the color to 0x07.
`default_nettype none

module text_console_cell_writer_unit #(
    parameter int SCREEN_COLUMNS = tccw_pkg::DEFAULT_COLUMNS,
    parameter int SCREEN_ROWS    = tccw_pkg::DEFAULT_ROWS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tuser,   // [0] cmd
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [10:0] cell_address, [26:11] cell_word,
                                        // [37:27] cursor_position, [39:38] zero
    output logic [1:0]       m_tuser    // [0] cell_write, [1] cursor_moved
);

    tccw_pkg::in_item_t in_item;
    tccw_pkg::in_item_t item;
    tccw_pkg::result_t  result;
    tccw_pkg::result_t  result_q;
    logic               item_valid;
    logic               room;
    logic               advance;

    assign in_item.cmd       = s_tuser;
    assign in_item.char_code = s_tdata;

    assign advance = item_valid && room;

    tccw_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .consume    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    tccw_engine #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS)
    ) u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (advance),
        .item   (item),
        .result (result)
    );

    tccw_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .result_in  (result),
        .room       (room),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .result_out (result_q)
    );

    assign m_tdata = {2'b00, result_q.cursor_position, result_q.cell_word,
                      result_q.cell_address};
    assign m_tuser = {result_q.cursor_moved, result_q.cell_write};

endmodule

`default_nettype wire

### test/tccw_cell_checker.sv
// ============================================================================
// Cell writer scoreboard
// Watches both streams of the text console cell writer, predicts the cell
// write and cursor update for every accepted byte, and compares each result.
// ============================================================================
`timescale 1ns / 1ps

module tccw_cell_checker #(
    parameter int COLUMNS = tccw_pkg::DEFAULT_COLUMNS,
    parameter int ROWS    = tccw_pkg::DEFAULT_ROWS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] char_code
    input  logic        s_tuser,    // [0] cmd
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,    // [10:0] cell_address, [26:11] cell_word,
                                    // [37:27] cursor_position, [39:38] zero
    input  logic [1:0]  m_tuser,    // [0] cell_write, [1] cursor_moved
    input  logic        drain_done,
    output int          mismatches,
    output int          pending,
    output int          items_seen,
    output int          writes_seen,
    output int          newlines_seen,
    output int          row_wraps
);

    // Shadow copy of the console state.
    int         cur_row;
    int         cur_col;
    logic [7:0] color;
    logic       escape_armed;

    tccw_pkg::result_t expected_cells[$];
    int                results_seen;

    function automatic logic [tccw_pkg::ADDR_W-1:0] cell_index(input int row, input int col);
        int idx;
        idx = row * COLUMNS + col;
        return idx[tccw_pkg::ADDR_W-1:0];
    endfunction

    task automatic advance_row();
        cur_row++;
        if (cur_row >= ROWS)
        begin
            cur_row = 0;
            row_wraps++;
        end
    endtask

    task automatic predict_cell_result(input logic cmd, input logic [7:0] code,
                                       output tccw_pkg::result_t r);
        r = '0;
        if (cmd == tccw_pkg::CMD_CHAR)
        begin
            if (code == tccw_pkg::ESCAPE_BYTE)
                escape_armed = 1'b1;
            else if (escape_armed)
            begin
                // Only the sixteen foreground codes change the color.
                if (code <= tccw_pkg::FG_MAX)
                    color = {color[7:4], code[3:0]};
                escape_armed = 1'b0;
            end
            else
            begin
                r.cell_write   = 1'b1;
                r.cell_address = cell_index(cur_row, cur_col);
                r.cell_word    = {color, code};
                cur_col++;
                if (cur_col >= COLUMNS)
                begin
                    cur_col = 0;
                    advance_row();
                end
                r.cursor_moved = 1'b1;
                writes_seen++;
            end
        end
        else if (code == tccw_pkg::NEWLINE_BYTE)
        begin
            cur_col = 0;
            advance_row();
            r.cursor_moved = 1'b1;
            newlines_seen++;
        end
        r.cursor_position = cell_index(cur_row, cur_col);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 25)
            $display("MISMATCH at result %0d: %s got 0x%0h, expected 0x%0h",
                     results_seen, what, got, want);
    endtask

    // Values seen at the falling edge are the ones the next rising edge accepts.
    always @(negedge clk)
    begin : watch
        tccw_pkg::result_t want;
        if (!rst_n)
        begin
            cur_row       = 0;
            cur_col       = 0;
            color         = tccw_pkg::COLOR_RESET;
            escape_armed  = 1'b0;
            expected_cells.delete();
            mismatches    = 0;
            items_seen    = 0;
            results_seen  = 0;
            writes_seen   = 0;
            newlines_seen = 0;
            row_wraps     = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_cell_result(s_tuser, s_tdata, want);
                expected_cells.push_back(want);
                items_seen++;
            end
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_cells.size() == 0)
                    report_mismatch("result with nothing expected",
                                    int'(m_tdata[31:0]), 0);
                else
                begin
                    want = expected_cells.pop_front();
                    if (m_tuser[0] !== want.cell_write)
                        report_mismatch("cell_write", int'(m_tuser[0]), int'(want.cell_write));
                    if (m_tdata[10:0] !== want.cell_address)
                        report_mismatch("cell_address", int'(m_tdata[10:0]),
                                        int'(want.cell_address));
                    if (m_tdata[26:11] !== want.cell_word)
                        report_mismatch("cell_word", int'(m_tdata[26:11]),
                                        int'(want.cell_word));
                    if (m_tuser[1] !== want.cursor_moved)
                        report_mismatch("cursor_moved", int'(m_tuser[1]),
                                        int'(want.cursor_moved));
                    if (m_tdata[37:27] !== want.cursor_position)
                        report_mismatch("cursor_position", int'(m_tdata[37:27]),
                                        int'(want.cursor_position));
                    if (m_tdata[39:38] !== 2'b00)
                        report_mismatch("tdata padding", int'(m_tdata[39:38]), 0);
                end
            end
        end
        pending = expected_cells.size();
    end

    always @(posedge drain_done)
    begin
        if (expected_cells.size() != 0)
            report_mismatch("results never delivered", 0, expected_cells.size());
    end

endmodule

### test/tb_text_console_cell_writer_unit.sv
// ============================================================================
// Text console cell writer testbench
// Drives directed and random byte streams with random idling, a long output
// hold-off and a full drain pause; the checker scores every result item.
// ============================================================================
`timescale 1ns / 1ps

module tb_text_console_cell_writer_unit;

    localparam int RANDOM_ITEMS = 950;
    localparam int HOLD_CYCLES  = 150;
    localparam int STALL_LIMIT  = 3000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;

    logic        drain_done = 1'b0;
    logic        calm       = 1'b0;
    logic        hold_req   = 1'b0;
    logic        hold_done  = 1'b0;
    int          sent       = 0;
    int          stall_cycles = 0;

    int mismatches, pending, items_seen, writes_seen, newlines_seen, row_wraps;

    always #5 clk = ~clk;

    text_console_cell_writer_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    tccw_cell_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .drain_done    (drain_done),
        .mismatches    (mismatches),
        .pending       (pending),
        .items_seen    (items_seen),
        .writes_seen   (writes_seen),
        .newlines_seen (newlines_seen),
        .row_wraps     (row_wraps)
    );

    // Offers one byte and returns right after the edge that accepts it.
    task automatic offer_byte(input logic cmd, input logic [7:0] code);
        logic rdy;
        if (!calm && $urandom_range(99) < 7)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tuser  <= cmd;
        do
        begin
            @(negedge clk);
            rdy = s_tready;
            @(posedge clk);
        end
        while (!rdy);
        sent++;
    endtask

    // Receiver: random stalls, one long hold-off on request.
    always
    begin
        @(posedge clk);
        if (hold_req && !hold_done)
        begin
            hold_done = 1'b1;
            m_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clk);
        end
        else
            m_tready <= calm || ($urandom_range(99) >= 7);
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("Watchdog: nothing accepted for %0d cycles", STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        int         kind;
        int         len;
        logic       paused;
        logic [7:0] b;
        paused = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: code extremes, wrap-free basics, escapes and controls.
        offer_byte(tccw_pkg::CMD_CHAR, 8'h41);
        offer_byte(tccw_pkg::CMD_CHAR, 8'h00);
        offer_byte(tccw_pkg::CMD_CHAR, 8'hFF);
        offer_byte(tccw_pkg::CMD_CONTROL, tccw_pkg::NEWLINE_BYTE);
        offer_byte(tccw_pkg::CMD_CONTROL, 8'h00);
        offer_byte(tccw_pkg::CMD_CONTROL, 8'hFF);
        offer_byte(tccw_pkg::CMD_CONTROL, tccw_pkg::ESCAPE_BYTE); // a control escape does not arm
        offer_byte(tccw_pkg::CMD_CHAR, 8'h0F);
        offer_byte(tccw_pkg::CMD_CHAR, tccw_pkg::ESCAPE_BYTE);
        offer_byte(tccw_pkg::CMD_CHAR, 8'h0F);
        offer_byte(tccw_pkg::CMD_CHAR, 8'h58);
        offer_byte(tccw_pkg::CMD_CHAR, tccw_pkg::ESCAPE_BYTE);
        offer_byte(tccw_pkg::CMD_CHAR, 8'h00);
        offer_byte(tccw_pkg::CMD_CHAR, 8'h7E);
        offer_byte(tccw_pkg::CMD_CHAR, tccw_pkg::ESCAPE_BYTE);   // a second escape keeps it armed
        offer_byte(tccw_pkg::CMD_CHAR, tccw_pkg::ESCAPE_BYTE);
        offer_byte(tccw_pkg::CMD_CHAR, 8'h04);
        offer_byte(tccw_pkg::CMD_CHAR, tccw_pkg::ESCAPE_BYTE);   // bold codes are swallowed
        offer_byte(tccw_pkg::CMD_CHAR, 8'h10);
        offer_byte(tccw_pkg::CMD_CHAR, tccw_pkg::ESCAPE_BYTE);
        offer_byte(tccw_pkg::CMD_CHAR, 8'h11);
        // Newline and other controls leave the escape armed.
        offer_byte(tccw_pkg::CMD_CHAR, tccw_pkg::ESCAPE_BYTE);
        offer_byte(tccw_pkg::CMD_CONTROL, tccw_pkg::NEWLINE_BYTE);
        offer_byte(tccw_pkg::CMD_CONTROL, 8'h55);
        offer_byte(tccw_pkg::CMD_CHAR, 8'h0C);
        offer_byte(tccw_pkg::CMD_CHAR, 8'h80);

        while (sent < RANDOM_ITEMS)
        begin
            if (!hold_req && sent >= 300)
                hold_req = 1'b1;
            calm = (sent >= 400) && (sent < 550);
            if (!paused && sent >= 650)
            begin
                // Let the pipeline drain completely before going on.
                paused = 1'b1;
                s_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (pending != 0);
            end
            kind = $urandom_range(99);
            if (kind < 45)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(60, 120)
                                               : $urandom_range(1, 20);
                repeat (len)
                begin
                    b = 8'($urandom_range(255));
                    if (b == tccw_pkg::ESCAPE_BYTE)
                        b = 8'h20;
                    offer_byte(tccw_pkg::CMD_CHAR, b);
                end
            end
            else if (kind < 60)
                repeat ($urandom_range(1, 4))
                    offer_byte(tccw_pkg::CMD_CONTROL, tccw_pkg::NEWLINE_BYTE);
            else if (kind < 80)
            begin
                offer_byte(tccw_pkg::CMD_CHAR, tccw_pkg::ESCAPE_BYTE);
                b = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                             : 8'($urandom_range(15));
                offer_byte(tccw_pkg::CMD_CHAR, b);
            end
            else if (kind < 90)
                offer_byte(1'($urandom_range(1)), 8'($urandom_range(255)));
            else
            begin
                offer_byte(tccw_pkg::CMD_CHAR, tccw_pkg::ESCAPE_BYTE);
                if ($urandom_range(1) == 0)
                    offer_byte(tccw_pkg::CMD_CHAR, tccw_pkg::ESCAPE_BYTE);
                else
                    offer_byte(tccw_pkg::CMD_CONTROL, 8'($urandom_range(255)));
                offer_byte(tccw_pkg::CMD_CHAR, 8'($urandom_range(31)));
            end
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        drain_done <= 1'b1;
        @(posedge clk);
        @(negedge clk);

        $display("Sent %0d items: %0d cell writes, %0d newlines, %0d row wraps.",
                 items_seen, writes_seen, newlines_seen, row_wraps);
        $display("Included a %0d-cycle output hold-off and one full drain pause.",
                 HOLD_CYCLES);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
